// ===== rtl/core/hdsx_pkg.sv =====
// Shared types and constants of the half-duplex serial transceiver with receive FIFO.
package hdsx_pkg;

  // Default receive FIFO depth.
  localparam int unsigned FIFO_DEPTH = 32;

  // Register reset values and fixed limits.
  localparam logic [15:0] BIT_TICKS_RST    = 16'd102;
  localparam logic [15:0] SETTLE_TICKS_RST = 16'd400;
  localparam logic [15:0] MIN_BIT_TICKS    = 16'd2;
  localparam logic [3:0]  BITS_PER_FRAME   = 4'd8;
  localparam int unsigned FILL_W           = 5;
  localparam int unsigned APB_DATA_W       = 32;
  localparam int unsigned APB_ADDR_W       = 3;

  // Host request codes.
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_SEND  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_FLUSH = 2'd3
  } hdsx_req_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_BUSY  = 2'd1,
    STATUS_EMPTY = 2'd2
  } hdsx_status_e;

  // Configuration register indexes.
  typedef enum logic {
    REG_BIT_TICKS    = 1'b0,
    REG_SETTLE_TICKS = 1'b1
  } hdsx_reg_e;

  // Receiver phases.
  typedef enum logic [1:0] {
    RX_IDLE = 2'd0,
    RX_HALF = 2'd1,
    RX_DATA = 2'd2,
    RX_STOP = 2'd3
  } hdsx_rx_phase_e;

  // Transmitter phases.
  typedef enum logic [2:0] {
    TX_IDLE   = 3'd0,
    TX_SETTLE = 3'd1,
    TX_START  = 3'd2,
    TX_DATA   = 3'd3,
    TX_GUARD  = 3'd4
  } hdsx_tx_phase_e;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0] req_type;
    logic       line_in;
    logic [7:0] tx_byte;
  } hdsx_req_t;

  // Result transaction payload.
  typedef struct packed {
    logic       line_out;
    logic       line_drive;
    logic       tx_select;
    logic [7:0] read_byte;
    logic [4:0] fill_count;
    logic [1:0] status;
  } hdsx_rsp_t;

  // Classified operation passed from the front end to the back end.
  typedef struct packed {
    hdsx_req_e  kind;
    logic       line;
    logic [7:0] data;
  } hdsx_op_t;

  // Configuration values seen by the back end.
  typedef struct packed {
    logic [15:0] bit_ticks;
    logic [15:0] settle_ticks;
  } hdsx_cfg_t;

endpackage

// ===== rtl/core/hdsx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hdsx_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/hdsx_front.sv =====
// Front end: accepts host transactions, classifies them and queues them for the back end.
module hdsx_front import hdsx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  hdsx_req_t in_data_i,
  output logic      op_valid_o,
  input  logic      op_take_i,
  output hdsx_op_t  op_o
);

  hdsx_op_t   queue_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  hdsx_op_t   op_new;

  // Classify the incoming request.
  always_comb begin
    op_new.kind = hdsx_req_e'(in_data_i.req_type);
    op_new.line = in_data_i.line_in;
    op_new.data = in_data_i.tx_byte;
  end

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign op_valid_o = (count_q != 2'd0);
  assign op_o       = queue_q[rd_ptr_q];

  // Queue pointer and occupancy update.
  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = op_take_i ? !rd_ptr_q : rd_ptr_q;
    unique case ({push, op_take_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= op_new;
    end
  end

endmodule

// ===== rtl/core/hdsx_back.sv =====
// Back end: receiver, transmitter and FIFO state update, with the result register.
module hdsx_back import hdsx_pkg::*; #(
  parameter int unsigned FifoDepth = FIFO_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  hdsx_cfg_t cfg_i,
  input  logic      op_valid_i,
  output logic      op_take_o,
  input  hdsx_op_t  op_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output hdsx_rsp_t out_data_o
);

  localparam int unsigned PtrW  = $clog2(FifoDepth);
  localparam int unsigned CntW  = PtrW + 1;
  localparam int unsigned DiffW = (CntW > FILL_W) ? CntW : FILL_W;

  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d, wp_inc, rp_inc;
  hdsx_rx_phase_e  rx_phase_q, rx_phase_d;
  hdsx_tx_phase_e  tx_phase_q, tx_phase_d;
  logic [15:0]     rx_timer_q, rx_timer_d, tx_timer_q, tx_timer_d;
  logic [3:0]      rx_cnt_q, rx_cnt_d, tx_cnt_q, tx_cnt_d;
  logic [7:0]      rx_shift_q, rx_shift_d, tx_shift_q, tx_shift_d;
  logic            line_prev_q, line_prev_d;
  logic            out_valid_q, pop_q;
  hdsx_rsp_t       rsp_q, rsp_d;
  hdsx_status_e    status;
  logic            fire, push, pop;
  logic [15:0]     bit_len, half_len, rx_dec, tx_dec;
  logic [3:0]      rx_cnt_inc, tx_cnt_inc;
  logic [DiffW-1:0] wp_ext, rp_ext, fill;
  logic [7:0]      ram_rdata;

  // A transaction leaves the queue when the result register is free next cycle.
  assign fire      = op_valid_i && (!out_valid_q || !out_stall_i);
  assign op_take_o = fire;

  // Bit timing derived from configuration.
  assign bit_len  = (cfg_i.bit_ticks < MIN_BIT_TICKS) ? MIN_BIT_TICKS : cfg_i.bit_ticks;
  assign half_len = bit_len >> 1;
  assign rx_dec   = (rx_timer_q != 16'd0) ? rx_timer_q - 16'd1 : rx_timer_q;
  assign tx_dec   = (tx_timer_q != 16'd0) ? tx_timer_q - 16'd1 : tx_timer_q;
  assign rx_cnt_inc = rx_cnt_q + 4'd1;
  assign tx_cnt_inc = tx_cnt_q + 4'd1;

  // Ring pointer increments wrap at the FIFO depth.
  assign wp_inc = (wp_q == PtrW'(FifoDepth - 1)) ? '0 : wp_q + PtrW'(1);
  assign rp_inc = (rp_q == PtrW'(FifoDepth - 1)) ? '0 : rp_q + PtrW'(1);

  // Next-state logic for one operation.
  always_comb begin
    wp_d        = wp_q;
    rp_d        = rp_q;
    rx_phase_d  = rx_phase_q;
    tx_phase_d  = tx_phase_q;
    rx_timer_d  = rx_timer_q;
    tx_timer_d  = tx_timer_q;
    rx_cnt_d    = rx_cnt_q;
    tx_cnt_d    = tx_cnt_q;
    rx_shift_d  = rx_shift_q;
    tx_shift_d  = tx_shift_q;
    line_prev_d = line_prev_q;
    status      = STATUS_OK;
    push        = 1'b0;
    pop         = 1'b0;
    if (fire) begin
      unique case (op_i.kind)
        REQ_TICK: begin
          line_prev_d = op_i.line;
          if (tx_phase_q != TX_IDLE) begin
            // Transmitter owns the tick; the receiver is frozen.
            tx_timer_d = tx_dec;
            if (tx_dec == 16'd0) begin
              unique case (tx_phase_q)
                TX_SETTLE: begin
                  tx_phase_d = TX_START;
                  tx_timer_d = bit_len;
                end
                TX_START: begin
                  tx_phase_d = TX_DATA;
                  tx_cnt_d   = 4'd0;
                  tx_timer_d = bit_len;
                end
                TX_DATA: begin
                  tx_cnt_d   = tx_cnt_inc;
                  tx_timer_d = bit_len;
                  if (tx_cnt_inc >= BITS_PER_FRAME) begin
                    tx_phase_d = TX_GUARD;
                  end
                end
                default: begin
                  tx_phase_d = TX_IDLE;
                  tx_timer_d = 16'd0;
                end
              endcase
            end
          end else if (rx_phase_q == RX_IDLE) begin
            // A rising line edge starts a reception.
            if (op_i.line && !line_prev_q) begin
              rx_phase_d = RX_HALF;
              rx_timer_d = half_len;
              rx_cnt_d   = 4'd0;
              rx_shift_d = 8'd0;
            end
          end else begin
            rx_timer_d = rx_dec;
            if (rx_dec == 16'd0) begin
              unique case (rx_phase_q)
                RX_HALF: begin
                  rx_phase_d = RX_DATA;
                  rx_timer_d = bit_len;
                end
                RX_DATA: begin
                  if (op_i.line) begin
                    rx_shift_d[rx_cnt_q[2:0]] = 1'b1;
                  end
                  rx_cnt_d   = rx_cnt_inc;
                  rx_timer_d = bit_len;
                  if (rx_cnt_inc >= BITS_PER_FRAME) begin
                    rx_phase_d = RX_STOP;
                  end
                end
                RX_STOP: begin
                  push       = 1'b1;
                  rx_phase_d = RX_IDLE;
                  rx_timer_d = 16'd0;
                end
                default: begin
                  rx_phase_d = rx_phase_q;
                end
              endcase
            end
          end
        end
        REQ_SEND: begin
          if (tx_phase_q != TX_IDLE || rx_phase_q != RX_IDLE) begin
            status = STATUS_BUSY;
          end else begin
            tx_shift_d = op_i.data;
            tx_cnt_d   = 4'd0;
            if (cfg_i.settle_ticks != 16'd0) begin
              tx_phase_d = TX_SETTLE;
              tx_timer_d = cfg_i.settle_ticks;
            end else begin
              tx_phase_d = TX_START;
              tx_timer_d = bit_len;
            end
          end
        end
        REQ_READ: begin
          if (wp_q == rp_q) begin
            status = STATUS_EMPTY;
          end else begin
            pop  = 1'b1;
            rp_d = rp_inc;
          end
        end
        REQ_FLUSH: begin
          rp_d = wp_q;
        end
      endcase
    end
    // A push onto a full ring drops the oldest byte.
    if (push) begin
      wp_d = wp_inc;
      if (wp_inc == rp_q) begin
        rp_d = rp_inc;
      end
    end
  end

  // Result fields from the state after the operation.
  always_comb begin
    wp_ext = DiffW'(wp_d);
    rp_ext = DiffW'(rp_d);
    if (wp_d >= rp_d) begin
      fill = wp_ext - rp_ext;
    end else begin
      fill = wp_ext + DiffW'(FifoDepth) - rp_ext;
    end
    rsp_d            = '0;
    rsp_d.tx_select  = (tx_phase_d == TX_SETTLE) || (tx_phase_d == TX_START) ||
                       (tx_phase_d == TX_DATA);
    rsp_d.line_drive = (tx_phase_d == TX_START) || (tx_phase_d == TX_DATA);
    if (tx_phase_d == TX_START) begin
      rsp_d.line_out = 1'b1;
    end else if (tx_phase_d == TX_DATA) begin
      rsp_d.line_out = tx_shift_d[tx_cnt_d[2:0]];
    end
    rsp_d.fill_count = fill[FILL_W-1:0];
    rsp_d.status     = status;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      rp_q        <= '0;
      rx_phase_q  <= RX_IDLE;
      tx_phase_q  <= TX_IDLE;
      rx_timer_q  <= 16'd0;
      tx_timer_q  <= 16'd0;
      rx_cnt_q    <= 4'd0;
      tx_cnt_q    <= 4'd0;
      line_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
      pop_q       <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      rx_phase_q  <= rx_phase_d;
      tx_phase_q  <= tx_phase_d;
      rx_timer_q  <= rx_timer_d;
      tx_timer_q  <= tx_timer_d;
      rx_cnt_q    <= rx_cnt_d;
      tx_cnt_q    <= tx_cnt_d;
      line_prev_q <= line_prev_d;
      if (fire) begin
        out_valid_q <= 1'b1;
        pop_q       <= pop;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Shift registers and the result register.
  always_ff @(posedge clk_i) begin
    rx_shift_q <= rx_shift_d;
    tx_shift_q <= tx_shift_d;
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  // Receive FIFO storage; a pop reads the entry at the old read pointer.
  hdsx_ram #(
    .Width (8),
    .Depth (FifoDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (wp_q),
    .wdata_i (rx_shift_q),
    .re_i    (pop),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  // The popped byte arrives from the RAM alongside the registered result.
  always_comb begin
    out_data_o           = rsp_q;
    out_data_o.read_byte = pop_q ? ram_rdata : 8'd0;
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/half_duplex_serial_xcvr_fifo_core.sv =====
// Top level of the half-duplex serial transceiver with receive FIFO.
// A request is registered in the front-end queue, and its result in the back-end result register.
// Throughput: one request per cycle unless the output stalls and the queue fills, set by the back-end update.
// A two-entry queue between front and back end absorbs output stalls.
// Reset clears all control state and loads bit_ticks 102 and settle_ticks 400.
// The FIFO storage is not cleared; no entry is read before it is written.
module half_duplex_serial_xcvr_fifo_core import hdsx_pkg::*; #(
  parameter int unsigned FifoDepth = FIFO_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  hdsx_req_t             in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output hdsx_rsp_t             out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  hdsx_cfg_t cfg_q, cfg_d;
  hdsx_reg_e reg_sel;
  logic      cfg_wr;
  logic      op_valid, op_take;
  hdsx_op_t  op;

  // Configuration register file.
  assign pready  = 1'b1;
  assign reg_sel = hdsx_reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_sel)
        REG_BIT_TICKS:    cfg_d.bit_ticks    = pwdata[15:0];
        REG_SETTLE_TICKS: cfg_d.settle_ticks = pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BIT_TICKS:    prdata = APB_DATA_W'(cfg_q.bit_ticks);
      REG_SETTLE_TICKS: prdata = APB_DATA_W'(cfg_q.settle_ticks);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_ticks    <= BIT_TICKS_RST;
      cfg_q.settle_ticks <= SETTLE_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end with the operation queue.
  hdsx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .op_valid_o (op_valid),
    .op_take_i  (op_take),
    .op_o       (op)
  );

  // Back end with the line state machines and the FIFO.
  hdsx_back #(
    .FifoDepth (FifoDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .op_valid_i  (op_valid),
    .op_take_o   (op_take),
    .op_i        (op),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // The back end only takes operations that the queue holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni) op_take |-> op_valid)
    else $error("back end took an operation from an empty queue");

  // A transaction accepted into an empty queue is visible to the back end on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !op_valid) |=> op_valid)
    else $error("accepted transaction did not reach the back end");

  // Without a pending operation, a delivered result leaves the output empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !op_valid) |=> !out_valid_o)
    else $error("result appeared without an operation");

  // The line is only driven while transmit is selected.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.line_drive) |-> out_data_o.tx_select)
    else $error("line driven while receive is selected");

endmodule
